// ----- design/htweb_pkg.sv -----
// Shared constants, ring table and lookup function for the hit time-window event builder.
package htweb_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int EVENT_BITS_DEF = 32;

  localparam int WINDOW_BITS = 24;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 24'd200;

  localparam int BOARD_BITS = 4;
  localparam int CHAN_BITS  = 6;
  localparam int TOA_BITS   = 16;
  localparam int TOT_BITS   = 16;
  localparam int HITS_BITS  = 16;
  localparam int KIND_BITS  = 8;
  localparam int RING_BITS  = 5;

  localparam int MAPPED_BOARDS = 4;

  localparam logic [RING_BITS-1:0] RING_MAP [32] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd15, 5'd1,  5'd16, 5'd2,
    5'd17, 5'd3,  5'd18, 5'd4,  5'd19, 5'd5,  5'd20, 5'd6,
    5'd21, 5'd7,  5'd22, 5'd8,  5'd23, 5'd9,  5'd24, 5'd10,
    5'd25, 5'd11, 5'd26, 5'd12, 5'd27, 5'd13, 5'd28, 5'd14
  };

  function automatic logic [RING_BITS-1:0] ring_of(
    input logic [BOARD_BITS-1:0] board,
    input logic [CHAN_BITS-1:0]  chan
  );
    logic [RING_BITS-1:0] ring;
    ring = RING_MAP[{board[1:0], chan[CHAN_BITS-1:3]}];
    if (board >= BOARD_BITS'(MAPPED_BOARDS)) begin
      ring = '0;
    end
    return ring;
  endfunction

endpackage

// ----- design/htweb_if.sv -----
// Hit and result channel interfaces with valid/ready handshake.
interface htweb_hit_if #(
  parameter int TIME_BITS = htweb_pkg::TIME_BITS_DEF
);
  import htweb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIME_BITS-1:0]  coarse_time;
  logic [BOARD_BITS-1:0] board;
  logic [CHAN_BITS-1:0]  channel;
  logic [TOA_BITS-1:0]   fine_toa;
  logic [TOT_BITS-1:0]   tot_count;
  logic [HITS_BITS-1:0]  hit_count;
  logic [KIND_BITS-1:0]  data_kind;

  modport source (
    output valid, coarse_time, board, channel, fine_toa, tot_count, hit_count, data_kind,
    input  ready
  );

  modport sink (
    input  valid, coarse_time, board, channel, fine_toa, tot_count, hit_count, data_kind,
    output ready
  );
endinterface

interface htweb_res_if #(
  parameter int TIME_BITS  = htweb_pkg::TIME_BITS_DEF,
  parameter int EVENT_BITS = htweb_pkg::EVENT_BITS_DEF
);
  import htweb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIME_BITS:0]    abs_time;
  logic [RING_BITS-1:0]  ring_number;
  logic [EVENT_BITS-1:0] event_number;
  logic [BOARD_BITS-1:0] board_out;
  logic [CHAN_BITS-1:0]  channel_out;
  logic [TOA_BITS-1:0]   toa_out;
  logic [TOT_BITS-1:0]   tot_out;
  logic [HITS_BITS-1:0]  hits_out;
  logic [KIND_BITS-1:0]  kind_out;

  modport source (
    output valid, abs_time, ring_number, event_number, board_out, channel_out, toa_out,
           tot_out, hits_out, kind_out,
    input  ready
  );

  modport sink (
    input  valid, abs_time, ring_number, event_number, board_out, channel_out, toa_out,
           tot_out, hits_out, kind_out,
    output ready
  );
endinterface

// ----- design/htweb_event_tracker.sv -----
// Event anchor and counter: window compare, re-anchor and saturating event count.
module htweb_event_tracker #(
  parameter int TIME_BITS  = htweb_pkg::TIME_BITS_DEF,
  parameter int EVENT_BITS = htweb_pkg::EVENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [TIME_BITS:0]                 abs_time,
  input  logic [htweb_pkg::WINDOW_BITS-1:0]  window,
  output logic [EVENT_BITS-1:0]              event_number
);
  import htweb_pkg::*;

  logic                  event_open;
  logic [TIME_BITS:0]    anchor;
  logic [TIME_BITS:0]    anchor_next;
  logic [EVENT_BITS-1:0] counter;
  logic [EVENT_BITS-1:0] counter_next;
  logic [TIME_BITS+1:0]  limit;
  logic                  later;

  always_comb begin
    limit = {1'b0, anchor} + (TIME_BITS+2)'(window);
    later = {1'b0, abs_time} > limit;
    anchor_next  = anchor;
    counter_next = counter;
    if (!event_open) begin
      anchor_next  = abs_time;
      counter_next = EVENT_BITS'(1);
    end else if (later) begin
      anchor_next = abs_time;
      if (counter != '1) begin
        counter_next = counter + EVENT_BITS'(1);
      end
    end
  end

  assign event_number = counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_open <= 1'b0;
      anchor     <= '0;
      counter    <= EVENT_BITS'(1);
    end else if (step) begin
      event_open <= 1'b1;
      anchor     <= anchor_next;
      counter    <= counter_next;
    end
  end

endmodule

// ----- design/hit_time_window_event_builder_top.sv -----
// Top level of the hit time-window event builder: input stage, event tracking, result stage.
//
//   channel   modport  transfer when        carries
//   hit_in    sink     valid & ready        one hit: coarse time, board, channel, ToA, pass-through
//   res_out   source   valid & ready        one result per hit: abs time, ring, event number
//   cfg       -        cfg_we               window_ticks, 24 bits
//
// Two register stages: the input stage forms abs time and ring, the result stage
// takes the event number. One hit per cycle sustained while res_out is ready.
// The window compare against the event anchor sets the result stage path.
// Synchronous reset empties both stages, clears the anchor, counter to 1, window to 200.
// A stalled result holds; each stage still takes a transfer whenever the next one frees up.
module hit_time_window_event_builder_top #(
  parameter int TIME_BITS  = htweb_pkg::TIME_BITS_DEF,
  parameter int EVENT_BITS = htweb_pkg::EVENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  htweb_hit_if.sink                         hit_in,
  htweb_res_if.source                       res_out,
  input  logic                              cfg_we,
  input  logic [htweb_pkg::WINDOW_BITS-1:0] cfg_data
);
  import htweb_pkg::*;

  logic [WINDOW_BITS-1:0] window;

  logic                  s1_valid;
  logic [TIME_BITS:0]    s1_abs;
  logic [RING_BITS-1:0]  s1_ring;
  logic [BOARD_BITS-1:0] s1_board;
  logic [CHAN_BITS-1:0]  s1_chan;
  logic [TOA_BITS-1:0]   s1_toa;
  logic [TOT_BITS-1:0]   s1_tot;
  logic [HITS_BITS-1:0]  s1_hits;
  logic [KIND_BITS-1:0]  s1_kind;

  logic                  out_valid;
  logic                  s2_take;
  logic                  s1_take;
  logic [EVENT_BITS-1:0] event_number;

  assign s2_take      = s1_valid && (!out_valid || res_out.ready);
  assign hit_in.ready = !s1_valid || !out_valid || res_out.ready;
  assign s1_take      = hit_in.valid && hit_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hit_in.ready) begin
      s1_valid <= hit_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_abs   <= (TIME_BITS+1)'(hit_in.coarse_time) + (TIME_BITS+1)'(hit_in.fine_toa);
      s1_ring  <= ring_of(hit_in.board, hit_in.channel);
      s1_board <= hit_in.board;
      s1_chan  <= hit_in.channel;
      s1_toa   <= hit_in.fine_toa;
      s1_tot   <= hit_in.tot_count;
      s1_hits  <= hit_in.hit_count;
      s1_kind  <= hit_in.data_kind;
    end
  end

  htweb_event_tracker #(
    .TIME_BITS  (TIME_BITS),
    .EVENT_BITS (EVENT_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (s2_take),
    .abs_time     (s1_abs),
    .window       (window),
    .event_number (event_number)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res_out.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      res_out.abs_time     <= s1_abs;
      res_out.ring_number  <= s1_ring;
      res_out.event_number <= event_number;
      res_out.board_out    <= s1_board;
      res_out.channel_out  <= s1_chan;
      res_out.toa_out      <= s1_toa;
      res_out.tot_out      <= s1_tot;
      res_out.hits_out     <= s1_hits;
      res_out.kind_out     <= s1_kind;
    end
  end

  assign res_out.valid = out_valid;

endmodule

// ----- test/htweb_event_checker.sv -----
// Event builder checker: tracks hit transfers, predicts each result and compares it with the block.
module htweb_event_checker #(
  parameter int TIME_BITS  = htweb_pkg::TIME_BITS_DEF,
  parameter int EVENT_BITS = htweb_pkg::EVENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  htweb_hit_if                              hit_mon,
  htweb_res_if                              res_mon,
  input  logic                              cfg_we,
  input  logic [htweb_pkg::WINDOW_BITS-1:0] cfg_data,
  output int                                mismatches,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import htweb_pkg::*;

  localparam logic [RING_BITS-1:0] RING_BY_GROUP [32] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd15, 5'd1,  5'd16, 5'd2,
    5'd17, 5'd3,  5'd18, 5'd4,  5'd19, 5'd5,  5'd20, 5'd6,
    5'd21, 5'd7,  5'd22, 5'd8,  5'd23, 5'd9,  5'd24, 5'd10,
    5'd25, 5'd11, 5'd26, 5'd12, 5'd27, 5'd13, 5'd28, 5'd14
  };

  typedef struct packed {
    logic [TIME_BITS:0]    abs_time;
    logic [RING_BITS-1:0]  ring;
    logic [EVENT_BITS-1:0] event_num;
    logic [BOARD_BITS-1:0] board;
    logic [CHAN_BITS-1:0]  chan;
    logic [TOA_BITS-1:0]   toa;
    logic [TOT_BITS-1:0]   tot;
    logic [HITS_BITS-1:0]  hits;
    logic [KIND_BITS-1:0]  kind;
  } hit_result_t;

  hit_result_t             pending_results [$];
  logic [WINDOW_BITS-1:0]  window_ticks;
  logic                    event_open;
  logic [TIME_BITS:0]      anchor_time;
  logic [EVENT_BITS-1:0]   event_count;
  int                      results_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin : track
    hit_result_t want;
    hit_result_t got;
    logic [TIME_BITS:0] t;
    if (rst) begin
      window_ticks = WINDOW_RESET;
      event_open   = 1'b0;
      anchor_time  = '0;
      event_count  = EVENT_BITS'(1);
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        window_ticks = cfg_data;
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.abs_time, res_mon.ring_number, res_mon.event_number,
                res_mon.board_out, res_mon.channel_out, res_mon.toa_out,
                res_mon.tot_out, res_mon.hits_out, res_mon.kind_out};
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d with nothing pending: abs=%0h ring=%0d event=%0d",
                     results_seen, got.abs_time, got.ring, got.event_num);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected abs=%0h ring=%0d event=%0d board=%0d chan=%0d",
                       want.abs_time, want.ring, want.event_num, want.board, want.chan);
              $display("           toa=%0h tot=%0h hits=%0h kind=%0h",
                       want.toa, want.tot, want.hits, want.kind);
              $display("  actual   abs=%0h ring=%0d event=%0d board=%0d chan=%0d",
                       got.abs_time, got.ring, got.event_num, got.board, got.chan);
              $display("           toa=%0h tot=%0h hits=%0h kind=%0h",
                       got.toa, got.tot, got.hits, got.kind);
            end
            mismatches++;
          end
        end
      end
      if (hit_mon.valid && hit_mon.ready) begin
        t = {1'b0, hit_mon.coarse_time} + (TIME_BITS+1)'(hit_mon.fine_toa);
        if (!event_open) begin
          event_open  = 1'b1;
          anchor_time = t;
          event_count = EVENT_BITS'(1);
        end else if ({1'b0, t} > {1'b0, anchor_time} + (TIME_BITS+2)'(window_ticks)) begin
          if (event_count != '1) begin
            event_count = event_count + EVENT_BITS'(1);
          end
          anchor_time = t;
        end
        want.abs_time  = t;
        want.ring      = (hit_mon.board > 4'd3) ? '0 :
                         RING_BY_GROUP[{hit_mon.board[1:0], hit_mon.channel[5:3]}];
        want.event_num = event_count;
        want.board     = hit_mon.board;
        want.chan      = hit_mon.channel;
        want.toa       = hit_mon.fine_toa;
        want.tot       = hit_mon.tot_count;
        want.hits      = hit_mon.hit_count;
        want.kind      = hit_mon.data_kind;
        pending_results = {pending_results, want};
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/hit_time_window_event_builder_top_tb.sv -----
// Testbench top for the hit time-window event builder: clock, reset, hit stimulus and verdict.
module hit_time_window_event_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htweb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 115;
  localparam longint unsigned PHASE_SPACING = 64'h1999_9999_9999;
  localparam logic [TIME_BITS_DEF-1:0] COARSE_MAX = '1;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [WINDOW_BITS-1:0] cfg_data;
  int                     cycle_count = 0;
  int                     mismatches;
  int                     outstanding;
  bit                     hold_req;
  int                     rx_hold_left;
  int                     rx_mode_left;
  rx_mode_t               rx_mode;
  bit                     gaps_on;
  int                     burst_left;
  longint unsigned        group_anchor;

  htweb_hit_if #(.TIME_BITS(TIME_BITS_DEF)) hit_ch ();
  htweb_res_if #(.TIME_BITS(TIME_BITS_DEF), .EVENT_BITS(EVENT_BITS_DEF)) res_ch ();

  hit_time_window_event_builder_top dut (
    .clk      (clk),
    .rst      (rst),
    .hit_in   (hit_ch),
    .res_out  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  htweb_event_checker event_check (
    .clk         (clk),
    .rst         (rst),
    .hit_mon     (hit_ch),
    .res_mon     (res_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hit_time_window_event_builder_top verification failed");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      res_ch.ready = 1'b0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      rx_hold_left = HOLD_CYCLES - 1;
      res_ch.ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PATTERN));
        rx_mode_left = $urandom_range(20, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_ALWAYS: res_ch.ready = 1'b1;
        RX_COIN:   res_ch.ready = ($urandom_range(0, 1) == 0);
        RX_MOSTLY: res_ch.ready = ($urandom_range(0, 9) != 0);
        default:   res_ch.ready = ((rx_mode_left % 5) < 2);
      endcase
    end
  end

  task automatic send_hit(
    input logic [TIME_BITS_DEF-1:0] coarse,
    input logic [BOARD_BITS-1:0]    board,
    input logic [CHAN_BITS-1:0]     chan,
    input logic [TOA_BITS-1:0]      toa,
    input logic [TOT_BITS-1:0]      tot,
    input logic [HITS_BITS-1:0]     hits,
    input logic [KIND_BITS-1:0]     kind
  );
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk) hit_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    hit_ch.coarse_time = coarse;
    hit_ch.board       = board;
    hit_ch.channel     = chan;
    hit_ch.fine_toa    = toa;
    hit_ch.tot_count   = tot;
    hit_ch.hit_count   = hits;
    hit_ch.data_kind   = kind;
    hit_ch.valid       = 1'b1;
    do @(posedge clk); while (!hit_ch.ready);
  endtask

  // send a hit at absolute time t with random split and random payload
  task automatic hit_at(input longint unsigned t);
    longint unsigned toa;
    logic [BOARD_BITS-1:0] board;
    toa = (t > 65535) ? $urandom_range(0, 65535) : $urandom_range(0, 32'(t));
    board = ($urandom_range(0, 9) < 7) ? BOARD_BITS'($urandom_range(0, 3)) :
                                         BOARD_BITS'($urandom_range(4, 15));
    send_hit(TIME_BITS_DEF'(t - toa), board, CHAN_BITS'($urandom), TOA_BITS'(toa),
             TOT_BITS'($urandom), HITS_BITS'($urandom), KIND_BITS'($urandom));
  endtask

  task automatic set_window(input logic [WINDOW_BITS-1:0] ticks);
    @(negedge clk) hit_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = ticks;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  task automatic run_phase(input int phase, input logic [WINDOW_BITS-1:0] ticks,
                           input bit with_gaps, input bit long_hold);
    int sent;
    int follow;
    bit hold_done;
    longint unsigned off;
    longint unsigned prev_off;
    longint unsigned extra;
    sent      = 0;
    hold_done = 1'b0;
    set_window(ticks);
    gaps_on      = with_gaps;
    burst_left   = 0;
    group_anchor = phase * PHASE_SPACING + ({$urandom, $urandom} & 64'hFF_FFFF_FFFF);
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 10) begin
        // out-of-order hit: earlier than the current anchor
        hit_at(group_anchor - $urandom_range(1, 1000));
        sent++;
      end else begin
        case ($urandom_range(0, 2))
          0:       extra = 0;
          1:       extra = $urandom_range(1, 16);
          default: extra = $urandom_range(0, 24'hFFFFFF);
        endcase
        group_anchor = group_anchor + 64'(ticks) + 1 + extra;
        hit_at(group_anchor);
        sent++;
        prev_off = 0;
        follow   = $urandom_range(0, 5);
        repeat (follow) begin
          if ($urandom_range(0, 3) == 0) begin
            off = 64'(ticks);
          end else begin
            off = prev_off + $urandom_range(0, 32'(ticks - prev_off));
          end
          prev_off = off;
          hit_at(group_anchor + off);
          sent++;
        end
      end
      if (long_hold && !hold_done && sent >= 20) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
    end
  endtask

  initial begin
    logic [WINDOW_BITS-1:0] phase_windows [8];
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    hit_ch.valid       = 1'b0;
    hit_ch.coarse_time = '0;
    hit_ch.board       = '0;
    hit_ch.channel     = '0;
    hit_ch.fine_toa    = '0;
    hit_ch.tot_count   = '0;
    hit_ch.hit_count   = '0;
    hit_ch.data_kind   = '0;
    res_ch.ready       = 1'b0;
    hold_req           = 1'b0;
    rx_hold_left       = 0;
    rx_mode_left       = 0;
    rx_mode            = RX_ALWAYS;
    gaps_on            = 1'b0;
    burst_left         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // default window: boundary, out-of-order, equal time, ring table corners
    send_hit(0, 0, 0, 0, 0, 0, 0);
    send_hit(200, 0, 32, 0, 1, 2, 3);
    send_hit(100, 0, 63, 101, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_hit(150, 1, 0, 0, 4, 5, 6);
    send_hit(201, 1, 63, 0, 7, 8, 9);
    send_hit(0, 2, 8, 201, 10, 11, 12);
    send_hit(300, 3, 56, 0, 13, 14, 15);
    send_hit(300, 4, 40, 0, 16, 17, 18);
    send_hit(300, 15, 63, 16'hFFFF, 19, 20, 21);
    send_hit(65835, 7, 17, 0, 22, 23, 24);
    // zero window
    set_window('0);
    send_hit(70000, 2, 24, 0, 25, 26, 27);
    send_hit(69999, 0, 0, 1, 28, 29, 30);
    send_hit(70000, 3, 0, 0, 31, 32, 33);
    send_hit(70001, 1, 40, 0, 34, 35, 36);
    // widest window
    set_window('1);
    send_hit(70001 + 24'hFFFFFF, 2, 47, 0, 37, 38, 39);
    send_hit(70002 + 24'hFFFFFF, 3, 15, 0, 40, 41, 42);

    phase_windows = '{24'd0, 24'd1, WINDOW_RESET, WINDOW_BITS'($urandom),
                      24'hFFFFFF, 24'd37, WINDOW_BITS'($urandom), 24'd5000};
    for (int p = 1; p <= 8; p++) begin
      run_phase(p, phase_windows[p-1], (p != 3) && (p != 5), p == 5);
    end

    // top of the time range
    set_window(WINDOW_RESET);
    gaps_on = 1'b0;
    send_hit(COARSE_MAX, 1, 5, 0, 43, 44, 45);
    send_hit(COARSE_MAX, 2, 50, 16'hFFFF, 46, 47, 48);
    send_hit(COARSE_MAX - 5, 0, 33, 16'hFFF0, 49, 50, 51);

    @(negedge clk) hit_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("hit_time_window_event_builder_top verification clean");
    end else begin
      $display("hit_time_window_event_builder_top verification failed");
    end
    $finish;
  end

endmodule
